// ===== rtl/core/cafr_pkg.sv =====
// ----------------------------------------------------------------------------
// cafr_pkg
// Shared types and constants for the chunk aligned fetch range planner.
// ----------------------------------------------------------------------------
package cafr_pkg;

    // field widths
    localparam int OFFSET_W = 48;
    localparam int SIZE_W   = 32;
    localparam int SUM_W    = 49;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 1;

    // default boundary table depth
    localparam int TABLE_DEPTH_DEF = 1024;

    // operation codes
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPAN     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_SPAN = 1'b1;

    // request item
    typedef struct packed {
        logic [1:0]          op;
        logic [OFFSET_W-1:0] hint_value;
        logic [OFFSET_W-1:0] query_offset;
        logic [SIZE_W-1:0]   query_size;
    } req_item_t;

    // result item
    typedef struct packed {
        logic [OFFSET_W-1:0] fetch_begin;
        logic [OFFSET_W-1:0] fetch_length;
    } rsp_item_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_U_PROBE,
        ST_GET_BEGIN,
        ST_L_PROBE,
        ST_GET_END,
        ST_GET_PREV,
        ST_DONE
    } cafr_state_t;

endpackage

// ===== rtl/core/cafr_ram.sv =====
// ----------------------------------------------------------------------------
// cafr_ram
// Generic simple dual port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module cafr_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/chunk_aligned_fetch_range.sv =====
// ----------------------------------------------------------------------------
// chunk_aligned_fetch_range
// Plans the chunk aligned window to fetch for a read, from a table of
// ascending chunk boundaries held in a synchronous RAM.
// ----------------------------------------------------------------------------
// Clear and append requests are done in the idle state. A query against an
// empty table goes to DONE, which loads its result into the output register.
// Otherwise the block runs two bisections over the boundary RAM, one probe
// per cycle on its single read port: U_PROBE and GET_BEGIN find the window
// start, L_PROBE and GET_END its end, and GET_PREV reads the boundary below
// the end when the window is wider than twice the minimum span. One request
// is in work at a time; a finished result sits in an output register, so the
// next request can be taken while the result waits. After reset the table is
// empty and needs no clearing pass.
// ----------------------------------------------------------------------------
module chunk_aligned_fetch_range #(
    parameter int TABLE_DEPTH = cafr_pkg::TABLE_DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [cafr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cafr_pkg::CFG_W-1:0]         cfg_data,
    input  logic                               req_valid,
    output logic                               req_ready,
    input  cafr_pkg::req_item_t                req_data,
    output logic                               rsp_valid,
    input  logic                               rsp_ready,
    output cafr_pkg::rsp_item_t                rsp_data
);

    import cafr_pkg::*;

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    cafr_state_t state_reg, state_next;

    logic [SIZE_W-1:0]   min_span_reg;
    logic [SIZE_W-1:0]   default_span_reg;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       lo_reg, lo_next;
    logic [CW-1:0]       hi_reg, hi_next;
    logic [CW-1:0]       mid_reg, mid_next;
    logic [CW-1:0]       l_reg, l_next;
    logic [OFFSET_W-1:0] offset_reg, offset_next;
    logic [SUM_W-1:0]    target_reg, target_next;
    logic [SUM_W-1:0]    read_end_reg, read_end_next;
    logic [OFFSET_W-1:0] begin_reg, begin_next;
    logic [OFFSET_W-1:0] end_reg, end_next;
    logic [OFFSET_W-1:0] length_reg, length_next;
    logic                rsp_valid_reg, rsp_valid_next;
    rsp_item_t           rsp_data_reg, rsp_data_next;

    // boundary RAM ports
    logic                wr_en;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic [OFFSET_W-1:0] rd_data;

    // probe step signals
    logic                go_right;
    logic [CW-1:0]       lo_step;
    logic [CW-1:0]       hi_step;
    logic [CW:0]         mid_sum;
    logic [CW-1:0]       mid_step;
    logic [CW-1:0]       begin_idx;
    logic [CW-1:0]       end_idx;
    logic [SIZE_W-1:0]   span;
    logic [OFFSET_W-1:0] width;
    logic [OFFSET_W-1:0] prev_len;
    logic [OFFSET_W-1:0] end_len;

    cafr_ram #(
        .WIDTH (OFFSET_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (wr_en),
        .waddr (count_reg[AW-1:0]),
        .wdata (req_data.hint_value),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_span_reg     <= '0;
            default_span_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MIN_SPAN:     min_span_reg     <= cfg_data;
                CFG_DEFAULT_SPAN: default_span_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // one bisection step on the word just read
    always_comb
    begin
        if (state_reg == ST_U_PROBE)
        begin
            go_right = (rd_data <= offset_reg);
        end
        else
        begin
            go_right = ({1'b0, rd_data} < target_reg);
        end
        lo_step  = go_right ? (mid_reg + ONE_C) : lo_reg;
        hi_step  = go_right ? hi_reg : mid_reg;
        mid_sum  = {1'b0, lo_step} + {1'b0, hi_step};
        mid_step = mid_sum[CW:1];
    end

    // window arithmetic
    always_comb
    begin
        span      = (min_span_reg > req_data.query_size) ? min_span_reg : req_data.query_size;
        begin_idx = ((lo_step != '0) && (lo_step < count_reg)) ? (lo_step - ONE_C) : '0;
        end_idx   = (lo_step >= count_reg) ? (count_reg - ONE_C) : lo_step;
        width     = rd_data - begin_reg;
        prev_len  = rd_data - begin_reg;
        end_len   = end_reg - begin_reg;
    end

    // sequencer: next state and datapath
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        l_next         = l_reg;
        offset_next    = offset_reg;
        target_next    = target_reg;
        read_end_next  = read_end_reg;
        begin_next     = begin_reg;
        end_next       = end_reg;
        length_next    = length_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_data_next  = rsp_data_reg;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = '0;
        req_ready      = (state_reg == ST_IDLE);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    unique case (req_data.op)
                        OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        OP_APPEND:
                        begin
                            if (count_reg < DEPTH_C)
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + ONE_C;
                            end
                        end
                        OP_QUERY:
                        begin
                            offset_next   = req_data.query_offset;
                            target_next   = {1'b0, req_data.query_offset}
                                            + SUM_W'(span);
                            read_end_next = {1'b0, req_data.query_offset}
                                            + SUM_W'(req_data.query_size);
                            if (count_reg == '0)
                            begin
                                begin_next  = req_data.query_offset;
                                length_next = (default_span_reg > req_data.query_size)
                                              ? OFFSET_W'(default_span_reg)
                                              : OFFSET_W'(req_data.query_size);
                                state_next  = ST_DONE;
                            end
                            else
                            begin
                                lo_next    = '0;
                                hi_next    = count_reg;
                                mid_next   = count_reg >> 1;
                                rd_en      = 1'b1;
                                rd_addr    = mid_next[AW-1:0];
                                state_next = ST_U_PROBE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_U_PROBE:
            begin
                // first boundary above the offset
                lo_next = lo_step;
                hi_next = hi_step;
                rd_en   = 1'b1;
                if (lo_step < hi_step)
                begin
                    mid_next = mid_step;
                    rd_addr  = mid_step[AW-1:0];
                end
                else
                begin
                    rd_addr    = begin_idx[AW-1:0];
                    state_next = ST_GET_BEGIN;
                end
            end
            ST_GET_BEGIN:
            begin
                begin_next = rd_data;
                lo_next    = '0;
                hi_next    = count_reg;
                mid_next   = count_reg >> 1;
                rd_en      = 1'b1;
                rd_addr    = mid_next[AW-1:0];
                state_next = ST_L_PROBE;
            end
            ST_L_PROBE:
            begin
                // first boundary at or above the target
                lo_next = lo_step;
                hi_next = hi_step;
                rd_en   = 1'b1;
                if (lo_step < hi_step)
                begin
                    mid_next = mid_step;
                    rd_addr  = mid_step[AW-1:0];
                end
                else
                begin
                    l_next     = lo_step;
                    rd_addr    = end_idx[AW-1:0];
                    state_next = ST_GET_END;
                end
            end
            ST_GET_END:
            begin
                end_next = rd_data;
                if ((l_reg < count_reg) && (l_reg != '0)
                    && (width > OFFSET_W'({min_span_reg, 1'b0})))
                begin
                    rd_en      = 1'b1;
                    rd_addr    = AW'(l_reg - ONE_C);
                    state_next = ST_GET_PREV;
                end
                else
                begin
                    length_next = width;
                    state_next  = ST_DONE;
                end
            end
            ST_GET_PREV:
            begin
                // pull back one boundary if it still covers the read
                length_next = ({1'b0, rd_data} >= read_end_reg) ? prev_len : end_len;
                state_next  = ST_DONE;
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next             = 1'b1;
                    rsp_data_next.fetch_begin  = begin_reg;
                    rsp_data_next.fetch_length = length_reg;
                    state_next                 = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        mid_reg      <= mid_next;
        l_reg        <= l_next;
        offset_reg   <= offset_next;
        target_reg   <= target_next;
        read_end_reg <= read_end_next;
        begin_reg    <= begin_next;
        end_reg      <= end_next;
        length_reg   <= length_next;
        rsp_data_reg <= rsp_data_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    // table fill never passes the depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("boundary count beyond table depth");

    // bisection only runs on a non-empty table and probes stored entries
    a_probe_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_U_PROBE || state_reg == ST_L_PROBE)
        |-> (count_reg != '0) && (mid_reg < count_reg) && (lo_reg <= mid_reg))
        else $error("probe outside stored boundaries");

    // table cannot change while a query is in work
    a_table_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE && $past(state_reg) != ST_IDLE) |-> $stable(count_reg))
        else $error("boundary count changed during a query");

    // a finished query is handed to the output register when it is free
    a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && (!rsp_valid_reg || rsp_ready))
        |=> rsp_valid_reg && state_reg == ST_IDLE)
        else $error("result not loaded from done state");

endmodule

// ===== sim/chunk_aligned_fetch_range_test.sv =====
// ----------------------------------------------------------------------------
// chunk_aligned_fetch_range_test
// Self-checking bench for the fetch window planner. Clear, append and query
// requests are sent over the request channel while a shadow boundary table
// predicts every window. Each returned window is checked field by field
// against the oldest prediction. Directed cases come first, then random
// traffic under several span settings, with random sender gaps and
// receiver stalls.
// ----------------------------------------------------------------------------
module chunk_aligned_fetch_range_test;

    timeunit 1ns;
    timeprecision 1ps;

    import cafr_pkg::*;

    localparam int         TAB_DEPTH   = TABLE_DEPTH_DEF;
    localparam int         CYCLE_LIMIT = 800000;
    localparam int         SETTLE      = 40;
    localparam logic [1:0] OP_UNUSED   = 2'd3;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic       req_valid = 1'b0;
    logic       req_ready;
    req_item_t  req_data = '0;
    logic       rsp_valid;
    logic       rsp_ready = 1'b0;
    rsp_item_t  rsp_data;

    // shadow state of the planner
    logic [OFFSET_W-1:0] bound_tab [TAB_DEPTH];
    int                  bound_cnt = 0;
    logic [CFG_W-1:0]    min_span_cfg = '0;
    logic [CFG_W-1:0]    default_span_cfg = '0;

    rsp_item_t window_q [$];
    rsp_item_t due_window;
    int        error_count = 0;
    int        cycle_count = 0;
    int        burst_left = 0;
    int        ready_cycle = 0;
    int        stall_left = 0;

    chunk_aligned_fetch_range dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

    always #10 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver stall pattern, cycling through four characters
    always @(negedge clk)
    begin
        logic ready_next;
        ready_cycle++;
        case ((ready_cycle / 512) % 4)
            0: ready_next = 1'b1;
            1: ready_next = 1'($urandom_range(0, 1));
            2: ready_next = ($urandom_range(0, 3) == 0);
            default:
            begin
                if (stall_left > 0)
                begin
                    stall_left--;
                    ready_next = 1'b0;
                end
                else if ($urandom_range(0, 15) == 0)
                begin
                    stall_left = $urandom_range(1, 30);
                    ready_next = 1'b0;
                end
                else
                begin
                    ready_next = 1'b1;
                end
            end
        endcase
        rsp_ready <= ready_next;
    end

    // window checker
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (window_q.size() == 0)
            begin
                $display("%0t unexpected window: expected none, actual begin %h length %h",
                         $time, rsp_data.fetch_begin, rsp_data.fetch_length);
                error_count++;
            end
            else
            begin
                due_window = window_q.pop_front();
                if (rsp_data.fetch_begin !== due_window.fetch_begin)
                begin
                    $display("%0t fetch_begin mismatch: expected %h actual %h",
                             $time, due_window.fetch_begin, rsp_data.fetch_begin);
                    error_count++;
                end
                if (rsp_data.fetch_length !== due_window.fetch_length)
                begin
                    $display("%0t fetch_length mismatch: expected %h actual %h",
                             $time, due_window.fetch_length, rsp_data.fetch_length);
                    error_count++;
                end
            end
        end
    end

    // first index whose boundary is above the key (strict) or at/above it
    function automatic int boundary_search(input logic [SUM_W-1:0] key, input bit strict);
        int   lo;
        int   hi;
        int   mid;
        logic go_right;
        lo = 0;
        hi = bound_cnt;
        while (lo < hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (strict)
                go_right = ({1'b0, bound_tab[mid]} <= key);
            else
                go_right = ({1'b0, bound_tab[mid]} < key);
            if (go_right)
                lo = mid + 1;
            else
                hi = mid;
        end
        return lo;
    endfunction

    // window for a query against the current table
    function automatic rsp_item_t plan_window(input req_item_t item);
        rsp_item_t           win;
        logic [SIZE_W-1:0]   span;
        logic [SUM_W-1:0]    target;
        logic [SUM_W-1:0]    read_end;
        logic [OFFSET_W-1:0] win_lo;
        logic [OFFSET_W-1:0] win_hi;
        logic [OFFSET_W-1:0] width;
        int                  u;
        int                  l;
        if (bound_cnt == 0)
        begin
            win.fetch_begin  = item.query_offset;
            win.fetch_length = OFFSET_W'((default_span_cfg > item.query_size) ?
                                         default_span_cfg : item.query_size);
            return win;
        end
        u = boundary_search({1'b0, item.query_offset}, 1'b1);
        win_lo = bound_tab[0];
        if (u > 0 && u < bound_cnt)
            win_lo = bound_tab[u - 1];
        span     = (min_span_cfg > item.query_size) ? min_span_cfg : item.query_size;
        target   = {1'b0, item.query_offset} + SUM_W'(span);
        read_end = {1'b0, item.query_offset} + SUM_W'(item.query_size);
        l = boundary_search(target, 1'b0);
        if (l >= bound_cnt)
        begin
            win_hi = bound_tab[bound_cnt - 1];
        end
        else
        begin
            win_hi = bound_tab[l];
            width  = win_hi - win_lo;
            // pull a wide window back one boundary if that still covers the read
            if (width > OFFSET_W'({min_span_cfg, 1'b0}) && l > 0 &&
                {1'b0, bound_tab[l - 1]} >= read_end)
                win_hi = bound_tab[l - 1];
        end
        win.fetch_begin  = win_lo;
        win.fetch_length = win_hi - win_lo;
        return win;
    endfunction

    // apply one accepted request to the shadow state
    function automatic void model_request(input req_item_t item);
        case (item.op)
            OP_CLEAR:  bound_cnt = 0;
            OP_APPEND:
            begin
                if (bound_cnt < TAB_DEPTH)
                begin
                    bound_tab[bound_cnt] = item.hint_value;
                    bound_cnt++;
                end
            end
            OP_QUERY:  window_q.insert(window_q.size(), plan_window(item));
            default:   ;
        endcase
    endfunction

    function automatic logic [OFFSET_W-1:0] rand48();
        return OFFSET_W'({$urandom, $urandom});
    endfunction

    function automatic req_item_t make_req(input logic [1:0] op,
                                           input logic [OFFSET_W-1:0] hint,
                                           input logic [OFFSET_W-1:0] offset,
                                           input logic [SIZE_W-1:0] size);
        req_item_t item;
        item.op           = op;
        item.hint_value   = hint;
        item.query_offset = offset;
        item.query_size   = size;
        return item;
    endfunction

    // one request transfer, with bursts and random gaps in between
    task automatic send_req(input req_item_t item);
        @(negedge clk);
        if (burst_left == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 100 : $urandom_range(1, 30);
        end
        burst_left--;
        req_valid <= 1'b1;
        req_data  <= item;
        do
            @(posedge clk);
        while (!req_ready);
        model_request(item);
    endtask

    // stop sending and wait for every window still due
    task automatic drain_windows();
        @(negedge clk);
        req_valid <= 1'b0;
        burst_left = 0;
        while (window_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_spans(input logic [CFG_W-1:0] min_span, input logic [CFG_W-1:0] def_span);
        drain_windows();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MIN_SPAN;
        cfg_data  <= min_span;
        @(negedge clk);
        cfg_index <= CFG_DEFAULT_SPAN;
        cfg_data  <= def_span;
        @(negedge clk);
        cfg_we <= 1'b0;
        min_span_cfg     = min_span;
        default_span_cfg = def_span;
    endtask

    function automatic logic [SIZE_W-1:0] pick_size();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 32);
            1:       return $urandom_range(0, 2000);
            2:       return $urandom;
            default: return min_span_cfg + $urandom_range(0, 4);
        endcase
    endfunction

    // empty table: window is the read stretched to default_span
    task automatic test_empty_table();
        send_req(make_req(OP_QUERY, '0, '0, '0));
        send_req(make_req(OP_QUERY, '1, '1, '1));
        send_req(make_req(OP_CLEAR, '1, '1, '1));
        send_req(make_req(OP_UNUSED, rand48(), rand48(), $urandom));
        set_spans(32'd0, 32'd4096);
        send_req(make_req(OP_QUERY, '0, 48'h1000, 32'd100));
        send_req(make_req(OP_QUERY, '0, 48'h1000, 32'd10000));
        set_spans('1, '1);
        send_req(make_req(OP_QUERY, '0, 48'h7, 32'd5));
    endtask

    // ascending table: below, past, inside, exact hit, shrink, wide reads
    task automatic test_window_cases();
        set_spans(32'd16, 32'd0);
        send_req(make_req(OP_CLEAR, '0, '0, '0));
        send_req(make_req(OP_APPEND, 48'd100, '0, '0));
        send_req(make_req(OP_APPEND, 48'd200, '0, '0));
        send_req(make_req(OP_APPEND, 48'd300, '0, '0));
        send_req(make_req(OP_APPEND, 48'd400, '0, '0));
        send_req(make_req(OP_APPEND, 48'd1000, '0, '0));
        send_req(make_req(OP_APPEND, 48'd5000, '0, '0));
        send_req(make_req(OP_QUERY, '0, 48'd50, 32'd0));
        send_req(make_req(OP_QUERY, '0, 48'd6000, 32'd8));
        send_req(make_req(OP_QUERY, '0, 48'd250, 32'd10));
        send_req(make_req(OP_QUERY, '0, 48'd250, 32'd2000));
        send_req(make_req(OP_QUERY, '0, 48'd310, 32'd0));
        send_req(make_req(OP_QUERY, '0, 48'd400, 32'd0));
        send_req(make_req(OP_QUERY, '0, '1, '1));
        send_req(make_req(OP_UNUSED, '1, '1, '1));
        send_req(make_req(OP_APPEND, '1, '0, '0));
        send_req(make_req(OP_QUERY, '0, '1, 32'd0));
    endtask

    // unordered table, including a wide window with no boundary before its end
    task automatic test_unordered_table();
        set_spans(32'd0, 32'd64);
        send_req(make_req(OP_CLEAR, '0, '0, '0));
        send_req(make_req(OP_APPEND, 48'd5000, '0, '0));
        send_req(make_req(OP_APPEND, 48'd300, '0, '0));
        send_req(make_req(OP_APPEND, 48'd9000, '0, '0));
        send_req(make_req(OP_QUERY, '0, 48'd300, 32'd0));
        send_req(make_req(OP_QUERY, '0, 48'd0, 32'd0));
        for (int i = 0; i < 6; i++)
            send_req(make_req(OP_APPEND, rand48(), '0, '0));
        for (int i = 0; i < 6; i++)
            send_req(make_req(OP_QUERY, rand48(),
                              ($urandom_range(0, 1) != 0) ? bound_tab[$urandom_range(0, 8)]
                                                          : rand48(),
                              pick_size()));
        send_req(make_req(OP_CLEAR, '0, '0, '0));
        send_req(make_req(OP_QUERY, '0, 48'd12, 32'd3));
    endtask

    // fill the table, then appends beyond depth must be dropped
    task automatic test_full_table();
        logic [OFFSET_W-1:0] mark;
        set_spans(32'd500, 32'd0);
        send_req(make_req(OP_CLEAR, '0, '0, '0));
        mark = OFFSET_W'($urandom);
        for (int i = 0; i < TAB_DEPTH + 4; i++)
        begin
            send_req(make_req(OP_APPEND, mark, '0, '0));
            mark = mark + $urandom_range(1, 1000);
        end
        for (int i = 0; i < 12; i++)
            send_req(make_req(OP_QUERY, '0,
                              bound_tab[$urandom_range(0, TAB_DEPTH - 1)] +
                              $urandom_range(0, 600) - 300,
                              pick_size()));
        send_req(make_req(OP_QUERY, '0, '1, 32'd0));
        send_req(make_req(OP_QUERY, '0, '0, 32'd0));
        send_req(make_req(OP_UNUSED, rand48(), rand48(), $urandom));
        send_req(make_req(OP_CLEAR, '0, '0, '0));
        send_req(make_req(OP_QUERY, '0, rand48(), $urandom));
    endtask

    // mostly well-formed tables and queries, with some broken order and noise
    task automatic random_phase(input int count);
        int                  pick;
        logic [OFFSET_W-1:0] anchor;
        logic [OFFSET_W-1:0] step;
        for (int i = 0; i < count; i++)
        begin
            // hold off once until every window has come back
            if (i == count / 2)
                drain_windows();
            pick = $urandom_range(0, 99);
            if (pick < 3 || (bound_cnt >= 48 && pick < 30))
            begin
                send_req(make_req(OP_CLEAR, rand48(), rand48(), $urandom));
            end
            else if (pick < 40)
            begin
                if (bound_cnt == 0)
                    anchor = ($urandom_range(0, 3) == 0) ? rand48() : OFFSET_W'($urandom);
                else
                    anchor = bound_tab[bound_cnt - 1];
                step = ($urandom_range(0, 3) == 0) ? OFFSET_W'($urandom)
                                                   : OFFSET_W'($urandom_range(0, 200));
                send_req(make_req(OP_APPEND, anchor + step, rand48(), $urandom));
            end
            else if (pick < 88)
            begin
                if (bound_cnt == 0)
                    anchor = rand48();
                else
                    anchor = bound_tab[$urandom_range(0, bound_cnt - 1)];
                step = OFFSET_W'($urandom_range(0, 300));
                anchor = ($urandom_range(0, 1) != 0) ? anchor + step : anchor - step;
                send_req(make_req(OP_QUERY, rand48(), anchor, pick_size()));
            end
            else if (pick < 94)
            begin
                send_req(make_req(OP_APPEND, rand48(), rand48(), $urandom));
            end
            else
            begin
                send_req(make_req(2'($urandom_range(0, 3)), rand48(), rand48(), $urandom));
            end
        end
    endtask

    task automatic test_random();
        set_spans('0, '0);
        random_phase(120);
        set_spans('1, '1);
        random_phase(120);
        set_spans(32'd16, 32'd4096);
        random_phase(120);
        set_spans(32'd64, 32'd0);
        random_phase(120);
        set_spans($urandom, $urandom);
        random_phase(120);
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_table();
        test_window_cases();
        test_unordered_table();
        test_full_table();
        test_random();

        drain_windows();
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/cafr_pkg.sv
rtl/core/cafr_ram.sv
rtl/core/chunk_aligned_fetch_range.sv
sim/chunk_aligned_fetch_range_test.sv
